>>> src/pccf_pkg.sv
// Shared types and constants for the point cloud crop filter.
package pccf_pkg;

   localparam int COORD_W = 20;
   localparam int COEF_W  = 16;
   localparam int FRAC_W  = COEF_W - 2;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [63:0] QUAT_RESET = 64'h4000_0000_0000_0000;
   localparam logic [31:0] YAW_RESET  = 32'h4000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUAT   = 3'd0,
      CSR_OFFSET = 3'd1,
      CSR_POS    = 3'd2,
      CSR_YAW    = 3'd3,
      CSR_RANGE  = 3'd4,
      CSR_BAND   = 3'd5,
      CSR_SELF   = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_KEPT    = 3'd0,
      VERDICT_INVALID = 3'd1,
      VERDICT_HEIGHT  = 3'd2,
      VERDICT_RANGE   = 3'd3,
      VERDICT_SELF    = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [31:0] sensor_x;
      logic [31:0] sensor_y;
      logic [31:0] sensor_z;
   } req_payload_type;

   typedef struct packed {
      verdict_type                verdict;
      logic signed [COORD_W-1:0]  world_x;
      logic signed [COORD_W-1:0]  world_y;
      logic signed [COORD_W-1:0]  world_z;
   } rsp_payload_type;

endpackage

>>> src/point_cloud_crop_filter_unit.sv
// Point cloud crop filter: float to fixed, rotation, height/range/self box checks.
// Throughput: one transaction per cycle; stalled stages hold, empty stages fill in.
// Eight register stages: input, convert, rotate multiply, sum, round/offset,
// range/height, yaw multiply, verdict/output.
// Synchronous active-high reset clears stage valids and loads register defaults.
module point_cloud_crop_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pccf_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pccf_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  pccf_pkg::csr_index_type             csr_index,
   input  logic [pccf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W  = pccf_pkg::COORD_W;
   localparam int C  = pccf_pkg::COEF_W;
   localparam int F  = pccf_pkg::FRAC_W;
   localparam int QW = 2*C + 2;
   localparam int MW = 2*C + 2 - F;
   localparam int PW = MW + W;
   localparam int AW = PW + 2;
   localparam int DW = W + 1;
   localparam int YW = C + DW;
   localparam int RW = YW + 1;
   localparam int HW = W + 2;

   typedef struct packed {
      logic        bad;
      logic [W-1:0] val;
   } conv_type;

   function automatic conv_type f32_conv(input logic [31:0] b);
      logic [7:0]  e;
      logic [23:0] m;
      logic signed [9:0] k;
      logic [9:0]  s;
      logic [47:0] mag;
      conv_type    r;
      r   = '0;
      mag = '0;
      e   = b[30:23];
      m   = (e == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
      k   = $signed({2'b00, ((e == 8'd0) ? 8'd1 : e)}) - 10'sd142;
      s   = 10'(-k);
      if (e == 8'hFF) begin
         r.bad = 1'b1;
      end else if (m == 24'd0) begin
         mag = '0;
      end else if (k >= 0) begin
         if (k > 10'sd24) r.bad = 1'b1;
         else mag = {24'd0, m} << k[4:0];
      end else if (s >= 10'd26) begin
         mag = '0;
      end else begin
         mag = ({24'd0, m} + (48'd1 << (s[4:0] - 5'd1))) >> s[4:0];
      end
      if (b[31]) begin
         if (mag > (48'd1 << (W-1))) r.bad = 1'b1;
         r.val = W'(-mag);
      end else begin
         if (mag >= (48'd1 << (W-1))) r.bad = 1'b1;
         r.val = W'(mag);
      end
      return r;
   endfunction

   function automatic logic signed [QW-1:0] rnd_q(input logic signed [QW-1:0] v);
      logic [QW-1:0] mag;
      mag = v[QW-1] ? QW'(-v) : QW'(v);
      mag = (mag + (QW'(1) << (F-1))) >> F;
      return v[QW-1] ? $signed(-mag) : $signed(mag);
   endfunction

   function automatic logic signed [AW-1:0] rnd_a(input logic signed [AW-1:0] v);
      logic [AW-1:0] mag;
      mag = v[AW-1] ? AW'(-v) : AW'(v);
      mag = (mag + (AW'(1) << (F-1))) >> F;
      return v[AW-1] ? $signed(-mag) : $signed(mag);
   endfunction

   // configuration registers
   logic [63:0] q_ff;
   logic [59:0] off_ff;
   logic [59:0] pos_ff;
   logic [31:0] yaw_ff;
   logic [60:0] range_ff;
   logic [39:0] band_ff;
   logic [59:0] self_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= pccf_pkg::QUAT_RESET;
         off_ff   <= '0;
         pos_ff   <= '0;
         yaw_ff   <= pccf_pkg::YAW_RESET;
         range_ff <= '0;
         band_ff  <= '0;
         self_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            pccf_pkg::CSR_QUAT:   q_ff     <= csr_wdata;
            pccf_pkg::CSR_OFFSET: off_ff   <= csr_wdata[59:0];
            pccf_pkg::CSR_POS:    pos_ff   <= csr_wdata[59:0];
            pccf_pkg::CSR_YAW:    yaw_ff   <= csr_wdata[31:0];
            pccf_pkg::CSR_RANGE:  range_ff <= csr_wdata[60:0];
            pccf_pkg::CSR_BAND:   band_ff  <= csr_wdata[39:0];
            pccf_pkg::CSR_SELF:   self_ff  <= csr_wdata[59:0];
            default: ;
         endcase
      end
   end

   // rotation matrix from quaternion, two register steps
   logic signed [C-1:0] qw, qx, qy, qz;
   assign qw = $signed(q_ff[3*C +: C]);
   assign qx = $signed(q_ff[2*C +: C]);
   assign qy = $signed(q_ff[C +: C]);
   assign qz = $signed(q_ff[0 +: C]);

   logic signed [2*C-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   always_ff @(posedge clock) begin
      xx_ff <= (2*C)'(qx) * (2*C)'(qx);
      yy_ff <= (2*C)'(qy) * (2*C)'(qy);
      zz_ff <= (2*C)'(qz) * (2*C)'(qz);
      xy_ff <= (2*C)'(qx) * (2*C)'(qy);
      xz_ff <= (2*C)'(qx) * (2*C)'(qz);
      yz_ff <= (2*C)'(qy) * (2*C)'(qz);
      wx_ff <= (2*C)'(qw) * (2*C)'(qx);
      wy_ff <= (2*C)'(qw) * (2*C)'(qy);
      wz_ff <= (2*C)'(qw) * (2*C)'(qz);
   end

   localparam logic signed [MW-1:0] ONE = MW'(1) << F;

   logic signed [MW-1:0] m_ff [3][3];
   logic signed [MW-1:0] m_in [3][3];
   always_comb begin
      m_in[0][0] = ONE - MW'(rnd_q(QW'(2) * (QW'(yy_ff) + QW'(zz_ff))));
      m_in[0][1] = MW'(rnd_q(QW'(2) * (QW'(xy_ff) - QW'(wz_ff))));
      m_in[0][2] = MW'(rnd_q(QW'(2) * (QW'(xz_ff) + QW'(wy_ff))));
      m_in[1][0] = MW'(rnd_q(QW'(2) * (QW'(xy_ff) + QW'(wz_ff))));
      m_in[1][1] = ONE - MW'(rnd_q(QW'(2) * (QW'(xx_ff) + QW'(zz_ff))));
      m_in[1][2] = MW'(rnd_q(QW'(2) * (QW'(yz_ff) - QW'(wx_ff))));
      m_in[2][0] = MW'(rnd_q(QW'(2) * (QW'(xz_ff) - QW'(wy_ff))));
      m_in[2][1] = MW'(rnd_q(QW'(2) * (QW'(yz_ff) + QW'(wx_ff))));
      m_in[2][2] = ONE - MW'(rnd_q(QW'(2) * (QW'(xx_ff) + QW'(yy_ff))));
   end
   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   // register fields
   logic signed [W-1:0] off_v [3];
   logic signed [W-1:0] pos_x, pos_y, pos_z, band_min, band_max;
   logic signed [W-1:0] max_x, max_y, self_len, self_wid, self_inset;
   logic [W:0]          map2;
   logic signed [C-1:0] yaw_c, yaw_s;
   assign off_v[0]   = $signed(off_ff[2*W +: W]);
   assign off_v[1]   = $signed(off_ff[W +: W]);
   assign off_v[2]   = $signed(off_ff[0 +: W]);
   assign pos_x      = $signed(pos_ff[2*W +: W]);
   assign pos_y      = $signed(pos_ff[W +: W]);
   assign pos_z      = $signed(pos_ff[0 +: W]);
   assign band_min   = $signed(band_ff[W +: W]);
   assign band_max   = $signed(band_ff[0 +: W]);
   assign max_x      = $signed(range_ff[2*W+1 +: W]);
   assign max_y      = $signed(range_ff[W+1 +: W]);
   assign map2       = range_ff[0 +: W+1];
   assign self_len   = $signed(self_ff[2*W +: W]);
   assign self_wid   = $signed(self_ff[W +: W]);
   assign self_inset = $signed(self_ff[0 +: W]);
   assign yaw_c      = $signed(yaw_ff[C +: C]);
   assign yaw_s      = $signed(yaw_ff[0 +: C]);

   // stage enables: a stage moves when empty or when the next one moves
   logic [8:1] v_ff, v_in, en;
   always_comb begin
      en[8] = !v_ff[8] || !rsp_stall;
      for (int k = 7; k >= 1; k--) en[k] = !v_ff[k] || en[k+1];
      v_in[1] = en[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= 8; k++) v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
   end
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end
   assign req_stall = !en[1];
   assign rsp_valid = v_ff[8];

   // stage 1: input
   pccf_pkg::req_payload_type in_ff;

   // stage 2: conversion
   conv_type cx, cy, cz;
   assign cx = f32_conv(in_ff.sensor_x);
   assign cy = f32_conv(in_ff.sensor_y);
   assign cz = f32_conv(in_ff.sensor_z);
   logic signed [W-1:0] p_ff [3];
   logic                bad2_ff;

   // stage 3: rotation products
   logic signed [PW-1:0] pr_ff [3][3];
   logic signed [PW-1:0] pr_in [3][3];
   logic                 bad3_ff;
   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            pr_in[i][j] = PW'(m_ff[i][j]) * PW'(p_ff[j]);
   end

   // stage 4: sums
   logic signed [AW-1:0] acc_ff [3];
   logic signed [AW-1:0] acc_in [3];
   logic                 bad4_ff;
   always_comb begin
      for (int i = 0; i < 3; i++)
         acc_in[i] = AW'(pr_ff[i][0]) + AW'(pr_ff[i][1]) + AW'(pr_ff[i][2]);
   end

   // stage 5: round, offset, range of representation
   logic signed [AW-1:0] wf [3];
   logic signed [W-1:0]  w5_ff [3];
   logic signed [W-1:0]  w5_in [3];
   logic                 bad5_ff, bad5_in;
   always_comb begin
      bad5_in = bad4_ff;
      for (int i = 0; i < 3; i++) begin
         wf[i]    = rnd_a(acc_ff[i]) + AW'(off_v[i]);
         w5_in[i] = W'(wf[i]);
         if (AW'(w5_in[i]) != wf[i]) bad5_in = 1'b1;
      end
   end

   // stage 6: height and range box
   logic signed [DW-1:0] dx_in, dy_in, dx_ff, dy_ff, zmin, zmax, wz;
   logic [DW-1:0]        dxm, dym, limx0, limy0, limx, limy;
   logic                 hgt_in, rng_in, hgt6_ff, rng6_ff, bad6_ff;
   logic signed [W-1:0]  w6_ff [3];
   always_comb begin
      dx_in = DW'(w5_ff[0]) - DW'(pos_x);
      dy_in = DW'(w5_ff[1]) - DW'(pos_y);
      zmin  = DW'(pos_z) + DW'(band_min);
      zmax  = DW'(pos_z) + DW'(band_max);
      wz    = DW'(w5_ff[2]);
      hgt_in = (wz < zmin) || (wz > zmax);
      dxm   = dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in);
      dym   = dy_in[DW-1] ? DW'(-dy_in) : DW'(dy_in);
      limx0 = max_x[W-1] ? '0 : {1'b0, max_x[W-2:0], 1'b0};
      limy0 = max_y[W-1] ? '0 : {1'b0, max_y[W-2:0], 1'b0};
      limx  = (limx0 > map2) ? map2 : limx0;
      limy  = (limy0 > map2) ? map2 : limy0;
      rng_in = ({dxm, 1'b0} > HW'(limx)) || ({dym, 1'b0} > HW'(limy));
   end

   // stage 7: yaw products
   logic signed [YW-1:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   logic                 hgt7_ff, rng7_ff, bad7_ff;
   logic signed [W-1:0]  w7_ff [3];

   // stage 8: self box and verdict
   logic signed [RW-1:0] rx, ry;
   logic [RW-1:0]        rxm, rym;
   logic signed [HW-1:0] hl2, hw2;
   logic [HW-1:0]        hl2c, hw2c;
   logic                 self_hit;
   pccf_pkg::rsp_payload_type rsp_ff, rsp_in;
   always_comb begin
      rx   = RW'(cdx_ff) + RW'(sdy_ff);
      ry   = RW'(cdy_ff) - RW'(sdx_ff);
      rxm  = rx[RW-1] ? RW'(-rx) : RW'(rx);
      rym  = ry[RW-1] ? RW'(-ry) : RW'(ry);
      hl2  = HW'(self_len) - HW'(2) * HW'(self_inset);
      hw2  = HW'(self_wid) - HW'(2) * HW'(self_inset);
      hl2c = hl2[HW-1] ? '0 : HW'(hl2);
      hw2c = hw2[HW-1] ? '0 : HW'(hw2);
      self_hit = ({rxm, 1'b0} < ((RW+1)'(hl2c) << F)) &&
                 ({rym, 1'b0} < ((RW+1)'(hw2c) << F));
      rsp_in.world_x = w7_ff[0];
      rsp_in.world_y = w7_ff[1];
      rsp_in.world_z = w7_ff[2];
      if (bad7_ff) begin
         rsp_in.verdict = pccf_pkg::VERDICT_INVALID;
         rsp_in.world_x = '0;
         rsp_in.world_y = '0;
         rsp_in.world_z = '0;
      end else if (hgt7_ff) begin
         rsp_in.verdict = pccf_pkg::VERDICT_HEIGHT;
      end else if (rng7_ff) begin
         rsp_in.verdict = pccf_pkg::VERDICT_RANGE;
      end else if (self_hit) begin
         rsp_in.verdict = pccf_pkg::VERDICT_SELF;
      end else begin
         rsp_in.verdict = pccf_pkg::VERDICT_KEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) in_ff <= req_payload;
      if (en[2]) begin
         p_ff[0] <= $signed(cx.val);
         p_ff[1] <= $signed(cy.val);
         p_ff[2] <= $signed(cz.val);
         bad2_ff <= cx.bad || cy.bad || cz.bad;
      end
      if (en[3]) begin
         pr_ff   <= pr_in;
         bad3_ff <= bad2_ff;
      end
      if (en[4]) begin
         acc_ff  <= acc_in;
         bad4_ff <= bad3_ff;
      end
      if (en[5]) begin
         w5_ff   <= w5_in;
         bad5_ff <= bad5_in;
      end
      if (en[6]) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         hgt6_ff <= hgt_in;
         rng6_ff <= rng_in;
         bad6_ff <= bad5_ff;
         w6_ff   <= w5_ff;
      end
      if (en[7]) begin
         cdx_ff  <= YW'(yaw_c) * YW'(dx_ff);
         sdy_ff  <= YW'(yaw_s) * YW'(dy_ff);
         cdy_ff  <= YW'(yaw_c) * YW'(dy_ff);
         sdx_ff  <= YW'(yaw_s) * YW'(dx_ff);
         hgt7_ff <= hgt6_ff;
         rng7_ff <= rng6_ff;
         bad7_ff <= bad6_ff;
         w7_ff   <= w6_ff;
      end
      if (en[8]) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v_ff[1])
      else $error("input stalled with empty input stage");
   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("input stalled while output drains");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.verdict == pccf_pkg::VERDICT_INVALID) |->
      (rsp_payload.world_x == '0 && rsp_payload.world_y == '0 &&
       rsp_payload.world_z == '0))
      else $error("invalid transaction carries coordinates");
`endif

endmodule
